// ----- hw/rtl/montgomery_repeated_squaring_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Montgomery squaring engine
// Concurrent checks on clk, MRS_ASSERT disabled while rst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef MONTGOMERY_REPEATED_SQUARING_DEFINES_SVH
`define MONTGOMERY_REPEATED_SQUARING_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge out of reset
`define MRS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mrs check failed");
// Check a property also during reset
`define MRS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("mrs check failed");
`else
`define MRS_ASSERT(lbl, prop)
`define MRS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- hw/rtl/mrs_pkg.sv -----
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared types of the Montgomery squaring engine: commands and MAC port.
// ----------------------------------------------------------------------------
package mrs_pkg;

  // Input word commands
  typedef enum logic [1:0] {
    CMD_LOAD_MOD = 2'd0,
    CMD_LOAD_INV = 2'd1,
    CMD_LOAD_VAL = 2'd2,
    CMD_START    = 2'd3
  } cmd_t;

  // Request to the shared multiply-accumulate unit: a*b + c + d
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } mac_req_t;

  // Answer of the unit: low and high limb, done pulses for one cycle
  typedef struct packed {
    logic        done;
    logic [63:0] lo;
    logic [63:0] hi;
  } mac_res_t;

endpackage

// ----- hw/rtl/mrs_ram.sv -----
// ----------------------------------------------------------------------------
// mrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/mrs_mac.sv -----
// ----------------------------------------------------------------------------
// mrs_mac
// Limb multiply-accumulate a*b + c + d over four 32x32 partial products.
// ----------------------------------------------------------------------------
module mrs_mac #(
  parameter int LIMB_BITS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mrs_pkg::mac_req_t req,
  output mrs_pkg::mac_res_t res
);

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [127:0] acc_r;
  logic [1:0]   step_r;
  logic         busy_r;
  logic         done_r;
  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [63:0]  pp;
  logic [1:0]   sh_sel;
  logic [127:0] pp_sh;

  // Pick the halves for this step and align the partial product
  always_comb begin
    a_half = step_r[1] ? a_r[63:32] : a_r[31:0];
    b_half = step_r[0] ? b_r[63:32] : b_r[31:0];
    pp     = a_half * b_half;
    sh_sel = {1'b0, step_r[0]} + {1'b0, step_r[1]};
    pp_sh  = {64'b0, pp} << {sh_sel, 5'b0};
  end

  // Sequence the four steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= 2'd0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Hold operands and accumulate
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= {64'b0, req.c} + {64'b0, req.d};
    end else if (busy_r) begin
      acc_r <= acc_r + pp_sh;
    end
  end

  assign res.done = done_r;
  assign res.lo   = 64'(acc_r[LIMB_BITS-1:0]);
  assign res.hi   = 64'(acc_r[2*LIMB_BITS-1:LIMB_BITS]);

endmodule

// ----- hw/rtl/montgomery_repeated_squaring.sv -----
// ----------------------------------------------------------------------------
// montgomery_repeated_squaring
// Loads modulus, n' and start value limb by limb; on start applies the
// configured number of Montgomery squarings and streams the result limbs.
// ----------------------------------------------------------------------------
//   channel | direction | word
//   in_     | in        | cmd, limb_index, limb_value
//   out_    | out       | result_limb, result_index, last
//   apb     | in/out    | squaring_count at byte address 0
//
// A start word holds in_stall high while every squaring runs through one
// shared 4-step multiply-accumulate unit, one limb product at a time
// (2.5*LIMBS^2 + LIMBS/2 products per squaring, plus 2*LIMBS carry writes,
// sweeps of add, subtract and copy and the check state), then LIMBS result
// words are sent, each waiting while out_stall is high.
// Reset is synchronous and needs no clearing pass.
`include "montgomery_repeated_squaring_defines.svh"

module montgomery_repeated_squaring #(
  parameter int LIMBS     = 32,
  parameter int LIMB_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_cmd,
  input  logic [4:0]           in_limb_index,
  input  logic [LIMB_BITS-1:0] in_limb_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [LIMB_BITS-1:0] out_result_limb,
  output logic [4:0]           out_result_index,
  output logic                 out_last,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);

  localparam int LAW = (LIMBS > 1) ? $clog2(LIMBS) : 1;
  localparam int PAW = $clog2(2 * LIMBS);
  localparam int CW  = $clog2(2 * LIMBS) + 1;
  localparam int W   = LIMB_BITS;
  localparam logic [CW-1:0] L_C  = CW'(LIMBS);
  localparam logic [CW-1:0] K2_C = CW'(2 * LIMBS);

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_RD_A, ST_RD_B, ST_RD_C, ST_RD_D, ST_MAC, ST_NEXT,
    ST_CARRY, ST_ADD_RD, ST_ADD_WR, ST_SUB_RD, ST_SUB_WR, ST_CP_RD, ST_CP_WR,
    ST_EM_RD, ST_EM_LD, ST_EM_HOLD
  } state_t;

  // Product being built: x*x, m = t*n', m*n
  typedef enum logic [1:0] {PH_SQ, PH_M, PH_N} phase_t;

  state_t            state_r;
  phase_t            ph_r;
  logic [63:0]       count_r;
  logic [63:0]       remaining_r;
  logic [CW-1:0]     i_r;
  logic [CW-1:0]     j_r;
  logic [CW-1:0]     k_r;
  logic [W-1:0]      a_lat_r;
  logic [W-1:0]      b_lat_r;
  logic [W-1:0]      carry_r;
  logic              cy_r;
  logic              bw_r;
  logic              out_valid_r;
  logic [W-1:0]      out_limb_r;
  logic [4:0]        out_idx_r;
  logic              out_last_r;

  logic [CW-1:0]     ij;
  logic [CW-1:0]     keep_c;
  logic              in_acc;
  logic              cfg_wr;

  logic              mod_we, inv_we, val_we, prod_we, mscr_we, sum_we;
  logic [LAW-1:0]    mod_wa, inv_wa, val_wa, mscr_wa;
  logic [PAW-1:0]    prod_wa, sum_wa;
  logic [W-1:0]      val_wd, prod_wd, mscr_wd, sum_wd;
  logic [LAW-1:0]    mod_ra, inv_ra, val_ra, mscr_ra;
  logic [PAW-1:0]    prod_ra, sum_ra;
  logic [W-1:0]      mod_rd, inv_rd, val_rd, prod_rd, mscr_rd, sum_rd;

  logic [W-1:0]      a_src, b_src, d_src;
  logic              dst_we;
  logic [CW-1:0]     dst_addr;
  logic [W-1:0]      dst_data;
  logic [W:0]        add_s;
  logic [W:0]        sub_d;
  logic [W-1:0]      cp_data;

  mrs_pkg::mac_req_t mac_req;
  mrs_pkg::mac_res_t mac_res;

  assign in_acc = in_valid && !in_stall;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign ij     = i_r + j_r;
  assign keep_c = (ph_r == PH_M) ? L_C : K2_C;

  // Register read
  assign pready = 1'b1;
  assign prdata = (paddr == 4'd0) ? count_r : 64'd0;

  // Operand sources per product
  always_comb begin
    unique case (ph_r)
      PH_SQ: begin a_src = val_rd;  b_src = val_rd; d_src = prod_rd; end
      PH_M:  begin a_src = prod_rd; b_src = inv_rd; d_src = mscr_rd; end
      PH_N:  begin a_src = mscr_rd; b_src = mod_rd; d_src = sum_rd;  end
      default: begin a_src = val_rd; b_src = val_rd; d_src = prod_rd; end
    endcase
  end

  // Drive the shared unit
  always_comb begin
    mac_req.start = (state_r == ST_RD_D);
    mac_req.a     = 64'(a_lat_r);
    mac_req.b     = 64'(b_lat_r);
    mac_req.c     = (i_r == '0) ? 64'd0 : 64'(d_src);
    mac_req.d     = 64'(carry_r);
  end

  mrs_mac #(.LIMB_BITS(LIMB_BITS)) u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mac_req),
    .res  (mac_res)
  );

  // Sweep arithmetic: add the two products, subtract n, pick the result
  assign add_s   = {1'b0, sum_rd} + {1'b0, prod_rd} + (W+1)'(cy_r);
  assign sub_d   = {1'b0, sum_rd} - {1'b0, mod_rd} - (W+1)'(bw_r);
  assign cp_data = (cy_r || !bw_r) ? mscr_rd : sum_rd;

  // Product limb write back
  always_comb begin
    dst_we   = 1'b0;
    dst_addr = ij;
    dst_data = mac_res.lo[W-1:0];
    if (state_r == ST_MAC && mac_res.done) begin
      dst_we = 1'b1;
    end else if (state_r == ST_CARRY) begin
      dst_we   = 1'b1;
      dst_addr = i_r + L_C;
      dst_data = carry_r;
    end
  end

  // Route memory addresses and writes
  always_comb begin
    mod_we  = in_acc && (in_cmd == mrs_pkg::CMD_LOAD_MOD) && (7'(in_limb_index) < 7'(LIMBS));
    inv_we  = in_acc && (in_cmd == mrs_pkg::CMD_LOAD_INV) && (7'(in_limb_index) < 7'(LIMBS));
    mod_wa  = LAW'(in_limb_index);
    inv_wa  = LAW'(in_limb_index);
    val_we  = in_acc && (in_cmd == mrs_pkg::CMD_LOAD_VAL) && (7'(in_limb_index) < 7'(LIMBS));
    val_wa  = LAW'(in_limb_index);
    val_wd  = in_limb_value;
    prod_we = dst_we && (ph_r == PH_SQ);
    prod_wa = dst_addr[PAW-1:0];
    prod_wd = dst_data;
    mscr_we = dst_we && (ph_r == PH_M);
    mscr_wa = dst_addr[LAW-1:0];
    mscr_wd = dst_data;
    sum_we  = dst_we && (ph_r == PH_N);
    sum_wa  = dst_addr[PAW-1:0];
    sum_wd  = dst_data;
    mod_ra  = '0;
    inv_ra  = '0;
    val_ra  = '0;
    prod_ra = '0;
    mscr_ra = '0;
    sum_ra  = '0;
    unique case (state_r)
      ST_RD_A: begin
        val_ra  = i_r[LAW-1:0];
        prod_ra = i_r[PAW-1:0];
        mscr_ra = i_r[LAW-1:0];
      end
      ST_RD_B: begin
        val_ra = j_r[LAW-1:0];
        inv_ra = j_r[LAW-1:0];
        mod_ra = j_r[LAW-1:0];
      end
      ST_RD_C: begin
        prod_ra = ij[PAW-1:0];
        mscr_ra = ij[LAW-1:0];
        sum_ra  = ij[PAW-1:0];
      end
      ST_ADD_RD: begin
        sum_ra  = k_r[PAW-1:0];
        prod_ra = k_r[PAW-1:0];
      end
      ST_SUB_RD: begin
        sum_ra = PAW'(k_r + L_C);
        mod_ra = k_r[LAW-1:0];
      end
      ST_CP_RD: begin
        sum_ra  = PAW'(k_r + L_C);
        mscr_ra = k_r[LAW-1:0];
      end
      ST_EM_RD: begin
        val_ra = k_r[LAW-1:0];
      end
      default: begin
      end
    endcase
    unique case (state_r)
      ST_ADD_WR: begin
        sum_we = 1'b1;
        sum_wa = k_r[PAW-1:0];
        sum_wd = add_s[W-1:0];
      end
      ST_SUB_WR: begin
        mscr_we = 1'b1;
        mscr_wa = k_r[LAW-1:0];
        mscr_wd = sub_d[W-1:0];
      end
      ST_CP_WR: begin
        val_we = 1'b1;
        val_wa = k_r[LAW-1:0];
        val_wd = cp_data;
      end
      default: begin
      end
    endcase
  end

  mrs_ram #(.WIDTH(W), .DEPTH(LIMBS)) u_mod_ram (
    .clk(clk), .we(mod_we), .waddr(mod_wa), .wdata(in_limb_value),
    .raddr(mod_ra), .rdata(mod_rd)
  );

  mrs_ram #(.WIDTH(W), .DEPTH(LIMBS)) u_inv_ram (
    .clk(clk), .we(inv_we), .waddr(inv_wa), .wdata(in_limb_value),
    .raddr(inv_ra), .rdata(inv_rd)
  );

  mrs_ram #(.WIDTH(W), .DEPTH(LIMBS)) u_val_ram (
    .clk(clk), .we(val_we), .waddr(val_wa), .wdata(val_wd),
    .raddr(val_ra), .rdata(val_rd)
  );

  mrs_ram #(.WIDTH(W), .DEPTH(2 * LIMBS)) u_prod_ram (
    .clk(clk), .we(prod_we), .waddr(prod_wa), .wdata(prod_wd),
    .raddr(prod_ra), .rdata(prod_rd)
  );

  mrs_ram #(.WIDTH(W), .DEPTH(LIMBS)) u_mscr_ram (
    .clk(clk), .we(mscr_we), .waddr(mscr_wa), .wdata(mscr_wd),
    .raddr(mscr_ra), .rdata(mscr_rd)
  );

  mrs_ram #(.WIDTH(W), .DEPTH(2 * LIMBS)) u_sum_ram (
    .clk(clk), .we(sum_we), .waddr(sum_wa), .wdata(sum_wd),
    .raddr(sum_ra), .rdata(sum_rd)
  );

  // Sequencer: state, counters and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= PH_SQ;
      count_r     <= 64'd0;
      remaining_r <= 64'd0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
    end else begin
      if (cfg_wr && paddr == 4'd0) begin
        count_r <= pwdata;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && in_cmd == mrs_pkg::CMD_START) begin
            remaining_r <= count_r;
            state_r     <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          i_r     <= '0;
          j_r     <= '0;
          k_r     <= '0;
          carry_r <= '0;
          ph_r    <= PH_SQ;
          state_r <= (remaining_r == 64'd0) ? ST_EM_RD : ST_RD_A;
        end
        ST_RD_A: state_r <= ST_RD_B;
        ST_RD_B: begin
          a_lat_r <= a_src;
          state_r <= ST_RD_C;
        end
        ST_RD_C: begin
          b_lat_r <= b_src;
          state_r <= ST_RD_D;
        end
        ST_RD_D: state_r <= ST_MAC;
        ST_MAC: begin
          if (mac_res.done) begin
            carry_r <= mac_res.hi[W-1:0];
            state_r <= ST_NEXT;
          end
        end
        ST_NEXT, ST_CARRY: begin
          if (state_r == ST_NEXT && j_r + 1'b1 < L_C && ij + 1'b1 < keep_c) begin
            j_r     <= j_r + 1'b1;
            state_r <= ST_RD_A;
          end else if (state_r == ST_NEXT && i_r + L_C < keep_c) begin
            state_r <= ST_CARRY;
          end else if (i_r + 1'b1 < L_C) begin
            // advance to the next row
            i_r     <= i_r + 1'b1;
            j_r     <= '0;
            carry_r <= '0;
            state_r <= ST_RD_A;
          end else begin
            // product done: next product or the sweeps
            i_r     <= '0;
            j_r     <= '0;
            carry_r <= '0;
            k_r     <= '0;
            cy_r    <= 1'b0;
            unique case (ph_r)
              PH_SQ: begin ph_r <= PH_M; state_r <= ST_RD_A; end
              PH_M:  begin ph_r <= PH_N; state_r <= ST_RD_A; end
              default: state_r <= ST_ADD_RD;
            endcase
          end
        end
        ST_ADD_RD: state_r <= ST_ADD_WR;
        ST_ADD_WR: begin
          cy_r <= add_s[W];
          if (k_r == K2_C - 1'b1) begin
            k_r     <= '0;
            bw_r    <= 1'b0;
            state_r <= ST_SUB_RD;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= ST_ADD_RD;
          end
        end
        ST_SUB_RD: state_r <= ST_SUB_WR;
        ST_SUB_WR: begin
          bw_r <= sub_d[W];
          if (k_r == L_C - 1'b1) begin
            k_r     <= '0;
            state_r <= ST_CP_RD;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= ST_SUB_RD;
          end
        end
        ST_CP_RD: state_r <= ST_CP_WR;
        ST_CP_WR: begin
          if (k_r == L_C - 1'b1) begin
            remaining_r <= remaining_r - 64'd1;
            state_r     <= ST_CHECK;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= ST_CP_RD;
          end
        end
        ST_EM_RD: state_r <= ST_EM_LD;
        ST_EM_LD: begin
          out_valid_r <= 1'b1;
          out_limb_r  <= val_rd;
          out_idx_r   <= 5'(k_r);
          out_last_r  <= (k_r == L_C - 1'b1);
          state_r     <= ST_EM_HOLD;
        end
        ST_EM_HOLD: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            k_r         <= k_r + 1'b1;
            state_r     <= out_last_r ? ST_IDLE : ST_EM_RD;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_limb  = out_limb_r;
  assign out_result_index = out_idx_r;
  assign out_last         = out_last_r;

  // Checks
  `MRS_ASSERT(a_out_only_emit, out_valid |-> (state_r == ST_EM_HOLD))
  `MRS_ASSERT(a_ready_no_out, !in_stall |-> !out_valid)
  `MRS_ASSERT(a_mac_done_wait, mac_res.done |-> (state_r == ST_MAC))
  `MRS_ASSERT(a_last_index, (out_valid && out_last) |-> (out_result_index == 5'(LIMBS - 1)))
  `MRS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == ST_IDLE))

endmodule
